// ===== rtl/cgp_pkg.sv =====
// Package: widths, side-band types and saturation helper for the goal point pipeline.
package cgp_pkg;

    localparam int COORD_BITS   = 24;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 16;
    localparam int UNITS_PER_CM = 100;
    localparam int DIST_W       = (COORD_BITS > 23) ? COORD_BITS : 23;
    localparam int SQ_W         = 2 * COORD_BITS;
    localparam int ROOT_W       = COORD_BITS;
    localparam int REM_W        = COORD_BITS + 3;
    localparam int SQ_STEPS     = COORD_BITS;
    localparam int Q_W          = COORD_BITS + DIST_W;
    localparam int DREM_W       = COORD_BITS + 1;
    localparam int DIV_STEPS    = Q_W;

    localparam logic [CFG_IDX_W-1:0] REG_PREF    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DEADB   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_STOP    = CFG_IDX_W'(3);

    localparam logic [Q_W-1:0] LIM_NEG = Q_W'(1) << (COORD_BITS - 1);
    localparam logic [Q_W-1:0] LIM_POS = LIM_NEG - Q_W'(1);

    typedef struct packed {
        logic                  tv;
        logic                  nx;
        logic                  ny;
        logic [COORD_BITS-1:0] ax;
        logic [COORD_BITS-1:0] ay;
    } t_side;

    typedef struct packed {
        logic tv;
        logic hold;
        logic sx;
        logic sy;
    } t_dside;

    function automatic logic [COORD_BITS-1:0] sat_enc(input logic [Q_W-1:0] mag,
                                                      input logic neg);
        logic [Q_W-1:0] m;
        if (neg) begin
            m = (mag > LIM_NEG) ? LIM_NEG : mag;
            m = ~m + Q_W'(1);
        end else begin
            m = (mag > LIM_POS) ? LIM_POS : mag;
        end
        return m[COORD_BITS-1:0];
    endfunction

endpackage

// ===== rtl/cgp_in_if.sv =====
// Interface: target input channel.
interface cgp_in_if import cgp_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         target_valid;
    logic signed [COORD_BITS-1:0] rel_x;
    logic signed [COORD_BITS-1:0] rel_y;
    modport source (output valid, target_valid, rel_x, rel_y, input ready);
    modport sink   (input valid, target_valid, rel_x, rel_y, output ready);
endinterface

// ===== rtl/cgp_out_if.sv =====
// Interface: goal output channel.
interface cgp_out_if import cgp_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] goal_x;
    logic signed [COORD_BITS-1:0] goal_y;
    logic                         accepted;
    modport source (output valid, goal_x, goal_y, accepted, input ready);
    modport sink   (input valid, goal_x, goal_y, accepted, output ready);
endinterface

// ===== rtl/cgp_cfg_if.sv =====
// Interface: configuration write channel.
interface cgp_cfg_if import cgp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/cgp_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module cgp_sqrt import cgp_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  t_side           i_side,
    input  logic [SQ_W-1:0] i_rad,
    output logic            o_valid,
    output t_side           o_side,
    output logic [ROOT_W-1:0] o_root
);

    logic              w_v    [0:SQ_STEPS];
    t_side             w_side [0:SQ_STEPS];
    logic [SQ_W-1:0]   w_rad  [0:SQ_STEPS];
    logic [REM_W-1:0]  w_rem  [0:SQ_STEPS];
    logic [ROOT_W-1:0] w_root [0:SQ_STEPS];

    logic              r_v    [0:SQ_STEPS-1];
    t_side             r_side [0:SQ_STEPS-1];
    logic [SQ_W-1:0]   r_rad  [0:SQ_STEPS-1];
    logic [REM_W-1:0]  r_rem  [0:SQ_STEPS-1];
    logic [ROOT_W-1:0] r_root [0:SQ_STEPS-1];

    logic [SQ_W-1:0]   n_rad  [0:SQ_STEPS-1];
    logic [REM_W-1:0]  n_rem  [0:SQ_STEPS-1];
    logic [ROOT_W-1:0] n_root [0:SQ_STEPS-1];

    always_comb begin
        w_v[0]    = i_valid;
        w_side[0] = i_side;
        w_rad[0]  = i_rad;
        w_rem[0]  = '0;
        w_root[0] = '0;
        for (int k = 1; k <= SQ_STEPS; k++) begin
            w_v[k]    = r_v[k-1];
            w_side[k] = r_side[k-1];
            w_rad[k]  = r_rad[k-1];
            w_rem[k]  = r_rem[k-1];
            w_root[k] = r_root[k-1];
        end
    end

    always_comb begin
        for (int k = 0; k < SQ_STEPS; k++) begin
            logic [REM_W-1:0] sh;
            logic [REM_W-1:0] trial;
            sh    = {w_rem[k][REM_W-3:0], w_rad[k][SQ_W-1 -: 2]};
            trial = REM_W'({w_root[k], 2'b01});
            n_rad[k] = {w_rad[k][SQ_W-3:0], 2'b00};
            if (sh >= trial) begin
                n_rem[k]  = sh - trial;
                n_root[k] = {w_root[k][ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = sh;
                n_root[k] = {w_root[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SQ_STEPS; k++) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v[k];
            end
            if (i_en) begin
                r_side[k] <= w_side[k];
                r_rad[k]  <= n_rad[k];
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
            end
        end
    end

    assign o_valid = w_v[SQ_STEPS];
    assign o_side  = w_side[SQ_STEPS];
    assign o_root  = w_root[SQ_STEPS];

endmodule

// ===== rtl/cgp_div.sv =====
// Pipelined two-lane restoring divider with a shared divisor, one quotient bit per stage.
module cgp_div import cgp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  t_dside                i_side,
    input  logic [Q_W-1:0]        i_num_x,
    input  logic [Q_W-1:0]        i_num_y,
    input  logic [COORD_BITS-1:0] i_den,
    output logic                  o_valid,
    output t_dside                o_side,
    output logic [Q_W-1:0]        o_q_x,
    output logic [Q_W-1:0]        o_q_y
);

    logic                  w_v    [0:DIV_STEPS];
    t_dside                w_side [0:DIV_STEPS];
    logic [COORD_BITS-1:0] w_den  [0:DIV_STEPS];
    logic [Q_W-1:0]        w_nx   [0:DIV_STEPS];
    logic [Q_W-1:0]        w_ny   [0:DIV_STEPS];
    logic [DREM_W-1:0]     w_rx   [0:DIV_STEPS];
    logic [DREM_W-1:0]     w_ry   [0:DIV_STEPS];

    logic                  r_v    [0:DIV_STEPS-1];
    t_dside                r_side [0:DIV_STEPS-1];
    logic [COORD_BITS-1:0] r_den  [0:DIV_STEPS-1];
    logic [Q_W-1:0]        r_nx   [0:DIV_STEPS-1];
    logic [Q_W-1:0]        r_ny   [0:DIV_STEPS-1];
    logic [DREM_W-1:0]     r_rx   [0:DIV_STEPS-1];
    logic [DREM_W-1:0]     r_ry   [0:DIV_STEPS-1];

    logic [Q_W-1:0]        n_nx   [0:DIV_STEPS-1];
    logic [Q_W-1:0]        n_ny   [0:DIV_STEPS-1];
    logic [DREM_W-1:0]     n_rx   [0:DIV_STEPS-1];
    logic [DREM_W-1:0]     n_ry   [0:DIV_STEPS-1];

    always_comb begin
        w_v[0]    = i_valid;
        w_side[0] = i_side;
        w_den[0]  = i_den;
        w_nx[0]   = i_num_x;
        w_ny[0]   = i_num_y;
        w_rx[0]   = '0;
        w_ry[0]   = '0;
        for (int k = 1; k <= DIV_STEPS; k++) begin
            w_v[k]    = r_v[k-1];
            w_side[k] = r_side[k-1];
            w_den[k]  = r_den[k-1];
            w_nx[k]   = r_nx[k-1];
            w_ny[k]   = r_ny[k-1];
            w_rx[k]   = r_rx[k-1];
            w_ry[k]   = r_ry[k-1];
        end
    end

    always_comb begin
        for (int k = 0; k < DIV_STEPS; k++) begin
            logic [DREM_W-1:0] shx;
            logic [DREM_W-1:0] shy;
            logic [DREM_W-1:0] den;
            logic              bx;
            logic              by;
            den = {1'b0, w_den[k]};
            shx = {w_rx[k][DREM_W-2:0], w_nx[k][Q_W-1]};
            shy = {w_ry[k][DREM_W-2:0], w_ny[k][Q_W-1]};
            bx  = (shx >= den);
            by  = (shy >= den);
            n_rx[k] = bx ? shx - den : shx;
            n_ry[k] = by ? shy - den : shy;
            n_nx[k] = {w_nx[k][Q_W-2:0], bx};
            n_ny[k] = {w_ny[k][Q_W-2:0], by};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v[k];
            end
            if (i_en) begin
                r_side[k] <= w_side[k];
                r_den[k]  <= w_den[k];
                r_nx[k]   <= n_nx[k];
                r_ny[k]   <= n_ny[k];
                r_rx[k]   <= n_rx[k];
                r_ry[k]   <= n_ry[k];
            end
        end
    end

    assign o_valid = w_v[DIV_STEPS];
    assign o_side  = w_side[DIV_STEPS];
    assign o_q_x   = w_nx[DIV_STEPS];
    assign o_q_y   = w_ny[DIV_STEPS];

endmodule

// ===== rtl/chase_goal_point.sv =====
// Top level: goal point short of a relative target, fully pipelined.
//
// Channels: i_in carries target beats (target_valid, rel_x, rel_y),
// o_out carries goal beats (goal_x, goal_y, accepted), i_cfg writes the four
// registers by index (stand-off, deadband, reverse enable, no-target flag).
// Every input beat gives exactly one output beat, in order.
//
// From the accepting edge to the first edge at which the goal beat can be taken,
// a beat passes the input register (loaded at the accepting edge), squares, sum,
// COORD_BITS square root stages, decision, products, COORD_BITS + DIST_W
// divider stages and the output register.
// Throughput is one beat per cycle while the receiver does not stall; the
// pipeline is set by the one-bit-per-stage root and quotient recurrences.
//
// Reset clears all stage valid bits and loads the registers to stand-off 0,
// deadband 0, reverse off, no-target flag 1. Configuration is always ready.
// When the receiver stalls with a beat held at the output, the whole pipeline,
// bubbles included, holds and i_in.ready drops.
module chase_goal_point import cgp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    cgp_in_if.sink  i_in,
    cgp_cfg_if.sink i_cfg,
    cgp_out_if.source o_out
);

    logic en;

    logic [DIST_W-1:0] r_pref;
    logic [DIST_W-1:0] r_deadb;
    logic              r_rev;
    logic              r_stop;

    logic              r_s0_v;
    t_side             r_s0_side;
    logic              r_s1_v;
    t_side             r_s1_side;
    logic [SQ_W-1:0]   r_s1_sx;
    logic [SQ_W-1:0]   r_s1_sy;
    logic              r_s2_v;
    t_side             r_s2_side;
    logic [SQ_W-1:0]   r_s2_sum;

    logic              sq_v;
    t_side             sq_side;
    logic [ROOT_W-1:0] sq_root;

    logic                  r_s3_v;
    t_dside                r_s3_side;
    logic [COORD_BITS-1:0] r_s3_ax;
    logic [COORD_BITS-1:0] r_s3_ay;
    logic [COORD_BITS-1:0] r_s3_d;
    logic [DIST_W-1:0]     r_s3_m;

    logic                  r_s4_v;
    t_dside                r_s4_side;
    logic [Q_W-1:0]        r_s4_px;
    logic [Q_W-1:0]        r_s4_py;
    logic [COORD_BITS-1:0] r_s4_d;

    logic           dv_v;
    t_dside         dv_side;
    logic [Q_W-1:0] dv_qx;
    logic [Q_W-1:0] dv_qy;

    logic                  r_out_v;
    logic [COORD_BITS-1:0] r_gx;
    logic [COORD_BITS-1:0] r_gy;
    logic                  r_acc;

    t_side             n_s0_side;
    t_dside            n_s3_side;
    logic [DIST_W-1:0] n_s3_m;

    assign en          = !r_out_v || o_out.ready;
    assign i_in.ready  = en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pref  <= '0;
            r_deadb <= '0;
            r_rev   <= 1'b0;
            r_stop  <= 1'b1;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_PREF:    r_pref  <= DIST_W'(32'(i_cfg.data) * UNITS_PER_CM);
                REG_DEADB:   r_deadb <= DIST_W'(32'(i_cfg.data) * UNITS_PER_CM);
                REG_REVERSE: r_rev   <= i_cfg.data[0];
                REG_STOP:    r_stop  <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_s0_side.tv = i_in.target_valid;
        n_s0_side.nx = i_in.rel_x[COORD_BITS-1];
        n_s0_side.ny = i_in.rel_y[COORD_BITS-1];
        n_s0_side.ax = n_s0_side.nx ? COORD_BITS'(-i_in.rel_x) : COORD_BITS'(i_in.rel_x);
        n_s0_side.ay = n_s0_side.ny ? COORD_BITS'(-i_in.rel_y) : COORD_BITS'(i_in.rel_y);
    end

    always_comb begin
        logic [DIST_W-1:0] d;
        logic              ge;
        d  = DIST_W'(sq_root);
        ge = (d >= r_pref);
        n_s3_m = ge ? d - r_pref : r_pref - d;
        n_s3_side.tv   = sq_side.tv;
        n_s3_side.hold = !sq_side.tv || (d == '0) || (n_s3_m <= r_deadb) || (!ge && !r_rev);
        n_s3_side.sx   = sq_side.nx ^ !ge;
        n_s3_side.sy   = sq_side.ny ^ !ge;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v  <= 1'b0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_s0_v  <= i_in.valid;
            r_s1_v  <= r_s0_v;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= sq_v;
            r_s4_v  <= r_s3_v;
            r_out_v <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_side <= n_s0_side;
            r_s1_side <= r_s0_side;
            r_s1_sx   <= SQ_W'(r_s0_side.ax) * SQ_W'(r_s0_side.ax);
            r_s1_sy   <= SQ_W'(r_s0_side.ay) * SQ_W'(r_s0_side.ay);
            r_s2_side <= r_s1_side;
            r_s2_sum  <= r_s1_sx + r_s1_sy;
            r_s3_side <= n_s3_side;
            r_s3_ax   <= sq_side.ax;
            r_s3_ay   <= sq_side.ay;
            r_s3_d    <= sq_root;
            r_s3_m    <= n_s3_m;
            r_s4_side <= r_s3_side;
            r_s4_px   <= Q_W'(r_s3_ax) * Q_W'(r_s3_m);
            r_s4_py   <= Q_W'(r_s3_ay) * Q_W'(r_s3_m);
            r_s4_d    <= r_s3_d;
            r_acc     <= dv_side.tv ? 1'b1 : r_stop;
            r_gx      <= dv_side.hold ? '0 : sat_enc(dv_qx, dv_side.sx);
            r_gy      <= dv_side.hold ? '0 : sat_enc(dv_qy, dv_side.sy);
        end
    end

    cgp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s2_v),
        .i_side  (r_s2_side),
        .i_rad   (r_s2_sum),
        .o_valid (sq_v),
        .o_side  (sq_side),
        .o_root  (sq_root)
    );

    cgp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s4_v),
        .i_side  (r_s4_side),
        .i_num_x (r_s4_px),
        .i_num_y (r_s4_py),
        .i_den   (r_s4_d),
        .o_valid (dv_v),
        .o_side  (dv_side),
        .o_q_x   (dv_qx),
        .o_q_y   (dv_qy)
    );

    assign o_out.valid    = r_out_v;
    assign o_out.goal_x   = r_gx;
    assign o_out.goal_y   = r_gy;
    assign o_out.accepted = r_acc;

endmodule

// ===== dv/testbench.sv =====
// Testbench: goal point pipeline checked beat by beat against an in-bench predictor.
module testbench;
    import cgp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(200);
    localparam int DRAIN_CYCLES = 3 * COORD_BITS + 16;
    localparam int PHASE_ITEMS = 180;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct {
        logic   gx_set;
        logic   tv;
        coord_t x;
        coord_t y;
        coord_t gx;
        coord_t gy;
        logic   acc;
    } target_row_t;

    typedef struct packed {
        coord_t gx;
        coord_t gy;
        logic   acc;
    } goal_t;

    typedef struct {
        logic [15:0] pref;
        logic [15:0] deadb;
        logic        rev;
        logic        stop;
        int          mode;
    } setting_t;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   send_gap_pct;
    int   stall_pct;
    goal_t goals_due[$];

    logic [15:0] cur_pref;
    logic [15:0] cur_deadb;
    logic        cur_rev;
    logic        cur_stop;

    cgp_in_if  in_if();
    cgp_cfg_if cfg_if();
    cgp_out_if out_if();

    chase_goal_point dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] root_floor(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic coord_t clamp_coord(input logic [63:0] mag, input logic neg);
        logic [63:0] lim;
        lim = 64'd1 << (COORD_BITS - 1);
        if (neg) begin
            if (mag > lim) mag = lim;
            return coord_t'(-mag);
        end
        if (mag > lim - 1) mag = lim - 1;
        return coord_t'(mag);
    endfunction

    function automatic goal_t goal_for(input logic tv, input coord_t x, input coord_t y);
        goal_t g;
        logic [63:0] ax, ay, d, p, b, m;
        logic nm;
        g = '{gx: '0, gy: '0, acc: 1'b1};
        if (!tv) begin
            g.acc = cur_stop;
            return g;
        end
        ax = x < 0 ? 64'(-64'(x)) : 64'(x);
        ay = y < 0 ? 64'(-64'(y)) : 64'(y);
        d = root_floor(ax * ax + ay * ay);
        if (d == 0) return g;
        p = 64'(cur_pref) * UNITS_PER_CM;
        b = 64'(cur_deadb) * UNITS_PER_CM;
        nm = d < p;
        m = nm ? p - d : d - p;
        if (m <= b) return g;
        if (nm && !cur_rev) return g;
        g.gx = clamp_coord((ax * m) / d, (x < 0) != nm);
        g.gy = clamp_coord((ay * m) / d, (y < 0) != nm);
        return g;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            REG_PREF:    cur_pref  = val;
            REG_DEADB:   cur_deadb = val;
            REG_REVERSE: cur_rev   = val[0];
            REG_STOP:    cur_stop  = val[0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input setting_t s);
        write_reg(REG_PREF, s.pref);
        write_reg(REG_DEADB, s.deadb);
        write_reg(REG_REVERSE, 16'(s.rev));
        write_reg(REG_STOP, 16'(s.stop));
        write_reg(REG_SPARE, 16'($urandom));
        cfg_if.valid <= 1'b0;
        case (s.mode)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 67; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 67; end
            default: begin send_gap_pct = 15; stall_pct = 15; end
        endcase
    endtask

    task automatic wait_drained();
        while (goals_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_target(input logic tv, input coord_t x, input coord_t y,
                               input logic typed, input goal_t g);
        while ($urandom_range(99) < send_gap_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.target_valid <= tv;
        in_if.rel_x        <= x;
        in_if.rel_y        <= y;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        goals_due.insert(goals_due.size(), typed ? g : goal_for(tv, x, y));
    endtask

    function automatic coord_t pick_coord(input int kind);
        int lim;
        case (kind)
            0: return coord_t'($urandom);
            1: begin
                lim = int'(cur_pref) * UNITS_PER_CM + int'(cur_deadb) * UNITS_PER_CM + 2000;
                if (lim > 8388607) lim = 8388607;
                return coord_t'(int'($urandom_range(0, 2 * lim)) - lim);
            end
            2: return coord_t'(int'($urandom_range(0, 6)) - 3);
            default: return $urandom_range(1) ? coord_t'(8388607) : coord_t'(-8388608);
        endcase
    endfunction

    always @(posedge i_clk) begin
        goal_t g;
        if (out_if.valid && out_if.ready) begin
            if (goals_due.size() == 0) begin
                $error("goal beat with nothing expected");
                fail_count++;
            end else begin
                g = goals_due.pop_front();
                if (out_if.goal_x !== g.gx) begin
                    $error("goal_x expected %0d got %0d", g.gx, out_if.goal_x);
                    fail_count++;
                end
                if (out_if.goal_y !== g.gy) begin
                    $error("goal_y expected %0d got %0d", g.gy, out_if.goal_y);
                    fail_count++;
                end
                if (out_if.accepted !== g.acc) begin
                    $error("accepted expected %0b got %0b", g.acc, out_if.accepted);
                    fail_count++;
                end
            end
        end
        out_if.ready <= i_rst_n && ($urandom_range(99) >= stall_pct);
    end

    initial begin
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        target_row_t rows[$];
        setting_t    settings[$];
        goal_t       g;
        int          kind;
        int          w;
        logic        tv;

        fail_count   = 0;
        send_gap_pct = 0;
        stall_pct    = 0;
        cur_pref     = 0;
        cur_deadb    = 0;
        cur_rev      = 1'b0;
        cur_stop     = 1'b1;
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.target_valid = 1'b0;
        in_if.rel_x  = '0;
        in_if.rel_y  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data  = '0;
        out_if.ready = 1'b0;

        rows = '{
            '{1'b1, 1'b0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b1},
            '{1'b1, 1'b0, 24'sd12345, -24'sd777, 24'sd0, 24'sd0, 1'b1},
            '{1'b1, 1'b1, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b1},
            '{1'b1, 1'b1, -24'sd8388608, 24'sd0, -24'sd8388608, 24'sd0, 1'b1},
            '{1'b1, 1'b1, 24'sd8388607, 24'sd0, 24'sd8388607, 24'sd0, 1'b1},
            '{1'b1, 1'b1, 24'sd0, -24'sd8388608, 24'sd0, -24'sd8388608, 1'b1},
            '{1'b1, 1'b1, 24'sd8388607, 24'sd8388607, 24'sd8388607, 24'sd8388607, 1'b1},
            '{1'b1, 1'b1, -24'sd8388608, -24'sd8388608, -24'sd8388608, -24'sd8388608,
              1'b1},
            '{1'b1, 1'b1, 24'sd1, 24'sd0, 24'sd1, 24'sd0, 1'b1},
            '{1'b0, 1'b1, -24'sd1, -24'sd1, 24'sd0, 24'sd0, 1'b0},
            '{1'b0, 1'b1, 24'sd3, 24'sd4, 24'sd0, 24'sd0, 1'b0},
            '{1'b0, 1'b1, -24'sd5000, 24'sd12000, 24'sd0, 24'sd0, 1'b0}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            g = '{gx: rows[i].gx, gy: rows[i].gy, acc: rows[i].acc};
            send_target(rows[i].tv, rows[i].x, rows[i].y, rows[i].gx_set, g);
        end
        in_if.valid <= 1'b0;
        wait_drained();

        settings = '{
            '{16'd0, 16'd0, 1'b0, 1'b1, 0},
            '{16'd65535, 16'd65535, 1'b1, 1'b0, 1},
            '{16'd100, 16'd5, 1'b0, 1'b0, 2},
            '{16'd300, 16'd0, 1'b1, 1'b1, 3},
            '{16'd65535, 16'd0, 1'b1, 1'b1, 0},
            '{16'd0, 16'd65535, 1'b0, 1'b0, 1},
            '{16'd50, 16'd2, 1'b1, 1'b0, 2},
            '{16'(0), 16'(0), 1'b0, 1'b1, 3}
        };
        settings[7].pref  = 16'($urandom_range(0, 65535));
        settings[7].deadb = 16'($urandom_range(0, 200));
        settings[7].rev   = 1'($urandom);
        settings[7].stop  = 1'($urandom);

        foreach (settings[s]) begin
            apply_setting(settings[s]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (s == 3 && n == PHASE_ITEMS / 2) begin
                    in_if.valid <= 1'b0;
                    while (goals_due.size() != 0) @(posedge i_clk);
                end
                w = $urandom_range(99);
                kind = w < 20 ? 0 : w < 85 ? 1 : w < 95 ? 2 : 3;
                tv = $urandom_range(99) < 88;
                send_target(tv, pick_coord(kind), pick_coord(kind), 1'b0, g);
            end
            in_if.valid <= 1'b0;
            wait_drained();
        end

        if (goals_due.size() != 0) begin
            $error("%0d goal beats never arrived", goals_due.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ===== chase_goal_point.f =====
rtl/cgp_pkg.sv
rtl/cgp_in_if.sv
rtl/cgp_out_if.sv
rtl/cgp_cfg_if.sv
rtl/cgp_sqrt.sv
rtl/cgp_div.sv
rtl/chase_goal_point.sv
dv/testbench.sv
